[rtl/core/rcsm_pkg.sv]
// Shared types and constants of the reference-counted slot manager.
`timescale 1ns / 1ps
package rcsm_pkg;

    localparam int ENTRIES = 32;
    localparam int REF_W   = 16;
    localparam int KEY_W   = 64;
    localparam int SLOT_W  = 5;
    localparam int STAT_W  = 3;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WIDE_W  = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

    typedef enum logic [STAT_W-1:0] {
        ST_HIT   = 3'd0,
        ST_FREE  = 3'd1,
        ST_EVICT = 3'd2,
        ST_FAIL  = 3'd3,
        ST_REL   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_HIT  = 2'd1,
        OP_INS  = 2'd2,
        OP_REL  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_LAUNCH = 3'd1,
        S_SCAN   = 3'd2,
        S_REL    = 3'd3,
        S_OUT    = 3'd4
    } t_state;

    // update broadcast to the slot cells
    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    // search token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic [REF_W-1:0] min_refs;
        logic [IDX_W-1:0] min_idx;
    } t_tok;

endpackage

[rtl/core/refcount_cache_slot_manager_unit.sv]
// Top level: request control, result register and the chain of slot cells.
//
//  channel | valid   | ready   | word
//  --------+---------+---------+-----------------------------------------------
//  request | i_valid | o_ready | i_req_type i_lookup_key i_load_ok i_release_slot
//  result  | o_valid | i_ready | o_status o_slot o_evicted_busy
//
// Acquire: a search token walks the slot chain one cell per cycle, launched in
// S_LAUNCH and read at the chain tail in S_SCAN. Release: handled in S_REL.
// One request at a time; o_ready is high only while no request is held.
// The result holds in its register until taken; reset clears used flags and control.
`timescale 1ns / 1ps
module refcount_cache_slot_manager_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_req_type,
    input  logic [rcsm_pkg::KEY_W-1:0]    i_lookup_key,
    input  logic                          i_load_ok,
    input  logic [rcsm_pkg::SLOT_W-1:0]   i_release_slot,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rcsm_pkg::STAT_W-1:0]   o_status,
    output logic [rcsm_pkg::SLOT_W-1:0]   o_slot,
    output logic                          o_evicted_busy
);

    rcsm_pkg::t_state             r_state;
    rcsm_pkg::t_state             n_state;
    logic                         r_req_type;
    logic [rcsm_pkg::KEY_W-1:0]   r_key;
    logic                         r_load_ok;
    logic [rcsm_pkg::SLOT_W-1:0]  r_rel_slot;
    rcsm_pkg::t_status            r_status;
    rcsm_pkg::t_status            n_status;
    logic [rcsm_pkg::IDX_W-1:0]   r_slot;
    logic [rcsm_pkg::IDX_W-1:0]   n_slot;
    logic                         r_busy;
    logic                         n_busy;
    logic                         w_load;
    logic                         w_accept;
    logic                         w_rel_ok;
    rcsm_pkg::t_cmd               w_cmd;
    rcsm_pkg::t_tok               w_launch;
    rcsm_pkg::t_tok               w_tok_in  [rcsm_pkg::ENTRIES];
    rcsm_pkg::t_tok               w_tok_out [rcsm_pkg::ENTRIES];
    rcsm_pkg::t_tok               w_tail;
    logic [rcsm_pkg::ENTRIES-1:0] w_tok_valid;

    assign o_ready  = (r_state == rcsm_pkg::S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_tail   = w_tok_out[rcsm_pkg::ENTRIES-1];
    assign w_rel_ok = (rcsm_pkg::WIDE_W'(r_rel_slot) < rcsm_pkg::WIDE_W'(rcsm_pkg::ENTRIES));

    always_comb begin
        w_launch          = '0;
        w_launch.valid    = (r_state == rcsm_pkg::S_LAUNCH);
        w_launch.min_refs = '1;
    end

    genvar g;
    generate
        for (g = 0; g < rcsm_pkg::ENTRIES; g++) begin : g_cell
            if (g > 0) begin : g_link
                assign w_tok_in[g] = w_tok_out[g-1];
            end else begin : g_head
                assign w_tok_in[g] = w_launch;
            end
            assign w_tok_valid[g] = w_tok_out[g].valid;
            rcsm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (rcsm_pkg::IDX_W'(g)),
                .i_key   (r_key),
                .i_cmd   (w_cmd),
                .i_tok   (w_tok_in[g]),
                .o_tok   (w_tok_out[g])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        w_cmd.op   = rcsm_pkg::OP_NONE;
        w_cmd.idx  = '0;
        w_load     = 1'b0;
        n_status   = rcsm_pkg::ST_FAIL;
        n_slot     = '0;
        n_busy     = 1'b0;
        case (r_state)
            rcsm_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = i_req_type ? rcsm_pkg::S_REL : rcsm_pkg::S_LAUNCH;
                end
            end
            rcsm_pkg::S_LAUNCH: begin
                n_state = rcsm_pkg::S_SCAN;
            end
            rcsm_pkg::S_SCAN: begin
                if (w_tail.valid) begin
                    w_load  = 1'b1;
                    n_state = rcsm_pkg::S_OUT;
                    if (r_key == '0) begin
                        n_status = rcsm_pkg::ST_FAIL;
                    end else if (w_tail.hit) begin
                        w_cmd.op  = rcsm_pkg::OP_HIT;
                        w_cmd.idx = w_tail.hit_idx;
                        n_status  = rcsm_pkg::ST_HIT;
                        n_slot    = w_tail.hit_idx;
                    end else if (!r_load_ok) begin
                        n_status = rcsm_pkg::ST_FAIL;
                    end else if (w_tail.free) begin
                        w_cmd.op  = rcsm_pkg::OP_INS;
                        w_cmd.idx = w_tail.free_idx;
                        n_status  = rcsm_pkg::ST_FREE;
                        n_slot    = w_tail.free_idx;
                    end else begin
                        w_cmd.op  = rcsm_pkg::OP_INS;
                        w_cmd.idx = w_tail.min_idx;
                        n_status  = rcsm_pkg::ST_EVICT;
                        n_slot    = w_tail.min_idx;
                        n_busy    = (w_tail.min_refs != '0);
                    end
                end
            end
            rcsm_pkg::S_REL: begin
                w_load    = 1'b1;
                n_state   = rcsm_pkg::S_OUT;
                n_status  = rcsm_pkg::ST_REL;
                n_slot    = rcsm_pkg::IDX_W'(r_rel_slot);
                w_cmd.op  = w_rel_ok ? rcsm_pkg::OP_REL : rcsm_pkg::OP_NONE;
                w_cmd.idx = rcsm_pkg::IDX_W'(r_rel_slot);
            end
            rcsm_pkg::S_OUT: begin
                if (i_ready) n_state = rcsm_pkg::S_IDLE;
            end
            default: begin
                n_state = rcsm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcsm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type <= i_req_type;
            r_key      <= i_lookup_key;
            r_load_ok  <= i_load_ok;
            r_rel_slot <= i_release_slot;
        end
        if (w_load) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_busy   <= n_busy;
        end
    end

    assign o_valid        = (r_state == rcsm_pkg::S_OUT);
    assign o_status       = r_status;
    assign o_slot         = (r_status == rcsm_pkg::ST_REL) ? r_rel_slot
                                                           : rcsm_pkg::SLOT_W'(r_slot);
    assign o_evicted_busy = r_busy;

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_valid))
        else $error("more than one search token in the slot chain");

    a_tail_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |-> (r_state == rcsm_pkg::S_SCAN))
        else $error("search token left the chain outside a scan");

    a_acq_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_req_type) |=> (r_state == rcsm_pkg::S_LAUNCH))
        else $error("acquire did not launch a search");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("request taken while a result is pending");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == rcsm_pkg::ST_FAIL)) |-> ((o_slot == '0) && !o_evicted_busy))
        else $error("failed acquire reports a slot");

    a_rel_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_req_type) |-> (o_status == rcsm_pkg::ST_REL))
        else $error("release gave a non-release status");
`endif

endmodule

[rtl/core/rcsm_cell.sv]
// One slot of the table: used flag, key and count, plus one stage of the search chain.
`timescale 1ns / 1ps
module rcsm_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [rcsm_pkg::IDX_W-1:0]   i_idx,
    input  logic [rcsm_pkg::KEY_W-1:0]   i_key,
    input  rcsm_pkg::t_cmd               i_cmd,
    input  rcsm_pkg::t_tok               i_tok,
    output rcsm_pkg::t_tok               o_tok
);

    logic                         r_used;
    logic [rcsm_pkg::KEY_W-1:0]   r_key;
    logic [rcsm_pkg::REF_W-1:0]   r_refs;
    rcsm_pkg::t_tok               r_tok;
    rcsm_pkg::t_tok               n_tok;
    logic                         w_sel;

    assign w_sel = (i_cmd.idx == i_idx);

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid) begin
            if (!i_tok.hit && r_used && (r_key == i_key)) begin
                n_tok.hit     = 1'b1;
                n_tok.hit_idx = i_idx;
            end
            if (!i_tok.free && !r_used) begin
                n_tok.free     = 1'b1;
                n_tok.free_idx = i_idx;
            end
            if (r_used && (r_refs < i_tok.min_refs)) begin
                n_tok.min_refs = r_refs;
                n_tok.min_idx  = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (w_sel && (i_cmd.op == rcsm_pkg::OP_INS)) begin
            r_used <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            case (i_cmd.op)
                rcsm_pkg::OP_HIT: begin
                    if (r_refs != '1) r_refs <= r_refs + rcsm_pkg::REF_W'(1);
                end
                rcsm_pkg::OP_INS: begin
                    r_key  <= i_key;
                    r_refs <= rcsm_pkg::REF_W'(1);
                end
                rcsm_pkg::OP_REL: begin
                    if (r_used && (r_refs != '0)) r_refs <= r_refs - rcsm_pkg::REF_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    assign o_tok = r_tok;

endmodule
